### hdl/poi_pkg.sv
// Package: constants, payload types and the quarter-wave sine table for the odometry integrator.
`timescale 1ns / 1ps
`default_nettype none
package poi_pkg;

  localparam int unsigned ATB     = 10;
  localparam int unsigned QUARTER = 1 << (ATB - 2);

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  localparam logic signed [47:0] POS_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] POS_MIN = {1'b1, {47{1'b0}}};

  typedef struct packed {
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_left;
    logic signed [23:0] yaw_rate;
    logic        [15:0] elapsed;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic        [31:0] heading;
  } out_word_t;

  typedef logic [14:0] qsine_tab_t [0:QUARTER];

  function automatic logic [14:0] quarter_sine(input logic [63:0] q);
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x    = (q * TWO_PI_Q30) >> ATB;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[14:0];
  endfunction

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    for (int i = 0; i <= int'(QUARTER); i++) begin
      tab[i] = quarter_sine(64'(i));
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

endpackage
`default_nettype wire

### hdl/planar_odometry_integrator_top.sv
// Top level: dead-reckoning pose integrator with one shared multiplier under a sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted word runs the sequencer steps SIN, COS, MA to MG, HEAD and WB until its pose
// loads into the output register. Two quarter-wave table reads give sine and cosine of the
// held heading. Then one shared 34x18 signed multiplier forms the four rotation products, the
// two displacements and the heading step, one product per cycle. HEAD adds the heading step and
// WB writes the pose back once the output register is free. A new word is accepted only in idle,
// after the last update has written back. The input side is not ready while an update runs. The
// output register lets a finished pose wait while the next word is accepted. The table has
// 2^(ATB-2)+1 entries of unsigned Q0.15 and the heading index truncates to ATB bits. Positions
// saturate at 48 bits signed; the heading wraps modulo 2^32.
module planar_odometry_integrator_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire poi_pkg::in_word_t  in_word_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output poi_pkg::out_word_t      out_word_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i
);

  localparam int unsigned ATB = poi_pkg::ATB;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_SIN  = 12'b0000_0000_0010,
    S_COS  = 12'b0000_0000_0100,
    S_MA   = 12'b0000_0000_1000,
    S_MB   = 12'b0000_0001_0000,
    S_MC   = 12'b0000_0010_0000,
    S_MD   = 12'b0000_0100_0000,
    S_ME   = 12'b0000_1000_0000,
    S_MF   = 12'b0001_0000_0000,
    S_MG   = 12'b0010_0000_0000,
    S_HEAD = 12'b0100_0000_0000,
    S_WB   = 12'b1000_0000_0000
  } state_e;

  state_e                 state_q, state_d;
  poi_pkg::in_word_t      in_q, in_d;
  logic signed [15:0]     sin_q, sin_d, cos_q, cos_d;
  logic signed [51:0]     prod_q, prod_d;
  logic signed [32:0]     wx_q, wx_d, wy_q, wy_d;
  logic signed [47:0]     x_q, x_d, y_q, y_d;
  logic        [31:0]     hd_q, hd_d;
  poi_pkg::out_word_t     out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic        [ATB-1:0]  tab_idx;
  logic        [ATB-3:0]  tab_r;
  logic        [ATB-2:0]  tab_q;
  logic signed [15:0]     tab_val;
  logic signed [15:0]     trig;

  logic signed [33:0]     mul_a;
  logic signed [17:0]     mul_b;
  logic signed [51:0]     mul_p;

  logic signed [47:0]     acc_sel;
  logic signed [42:0]     step;
  logic signed [51:0]     rnd;
  logic signed [48:0]     sum;
  logic signed [47:0]     sat;

  logic signed [17:0]     dt_ext;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    tab_idx = hd_q[31 -: ATB];
    if (state_q == S_COS) begin
      tab_idx = tab_idx + ATB'(poi_pkg::QUARTER);
    end
    tab_r   = tab_idx[ATB-3:0];
    tab_q   = tab_idx[ATB-2] ? (ATB-1)'(poi_pkg::QUARTER) - {1'b0, tab_r} : {1'b0, tab_r};
    tab_val = $signed({1'b0, poi_pkg::QSINE[tab_q]});
    trig    = tab_idx[ATB-1] ? -tab_val : tab_val;
  end

  assign dt_ext = $signed({2'b00, in_q.elapsed});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MA: begin
        mul_a = 34'(in_q.vel_forward);
        mul_b = 18'(cos_q);
      end
      S_MB: begin
        mul_a = 34'(in_q.vel_left);
        mul_b = 18'(sin_q);
      end
      S_MC: begin
        mul_a = 34'(in_q.vel_forward);
        mul_b = 18'(sin_q);
      end
      S_MD: begin
        mul_a = 34'(in_q.vel_left);
        mul_b = 18'(cos_q);
      end
      S_ME: begin
        mul_a = 34'(wx_q);
        mul_b = dt_ext;
      end
      S_MF: begin
        mul_a = 34'(wy_q);
        mul_b = dt_ext;
      end
      S_MG: begin
        mul_a = 34'(in_q.yaw_rate);
        mul_b = dt_ext;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    acc_sel = (state_q == S_MG) ? y_q : x_q;
    rnd     = prod_q + 52'sd256;
    step    = 43'(rnd >>> 9);
    sum     = 49'(acc_sel) + 49'(step);
    if (sum[48] != sum[47]) begin
      sat = sum[48] ? poi_pkg::POS_MIN : poi_pkg::POS_MAX;
    end else begin
      sat = sum[47:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    sin_d       = sin_q;
    cos_d       = cos_q;
    prod_d      = prod_q;
    wx_d        = wx_q;
    wy_d        = wy_q;
    x_d         = x_q;
    y_d         = y_q;
    hd_d        = hd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_word_i;
          state_d = S_SIN;
        end
      end
      S_SIN: begin
        sin_d   = trig;
        state_d = S_COS;
      end
      S_COS: begin
        cos_d   = trig;
        state_d = S_MA;
      end
      S_MA: begin
        prod_d  = mul_p;
        state_d = S_MB;
      end
      S_MB: begin
        wx_d    = prod_q[32:0];
        prod_d  = mul_p;
        state_d = S_MC;
      end
      S_MC: begin
        wx_d    = wx_q - prod_q[32:0];
        prod_d  = mul_p;
        state_d = S_MD;
      end
      S_MD: begin
        wy_d    = prod_q[32:0];
        prod_d  = mul_p;
        state_d = S_ME;
      end
      S_ME: begin
        wy_d    = wy_q + prod_q[32:0];
        prod_d  = mul_p;
        state_d = S_MF;
      end
      S_MF: begin
        x_d     = sat;
        prod_d  = mul_p;
        state_d = S_MG;
      end
      S_MG: begin
        y_d     = sat;
        prod_d  = mul_p;
        state_d = S_HEAD;
      end
      S_HEAD: begin
        hd_d    = hd_q + {prod_q[29:0], 2'b00};
        state_d = S_WB;
      end
      S_WB: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.pos_x   = x_q;
          out_d.pos_y   = y_q;
          out_d.heading = hd_q;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      hd_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      x_q         <= x_d;
      y_q         <= y_d;
      hd_q        <= hd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    sin_q  <= sin_d;
    cos_q  <= cos_d;
    prod_q <= prod_d;
    wx_q   <= wx_d;
    wy_q   <= wy_d;
    out_q  <= out_d;
  end

endmodule
`default_nettype wire

### hdl/poi_checker.sv
// Checker: port-level assertions for the odometry integrator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module poi_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire poi_pkg::out_word_t out_word_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after an accepted word");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an update in progress");

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_word_o))
    else $error("output word changed while stalled");

endmodule

bind planar_odometry_integrator_top poi_checker u_poi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
`default_nettype wire

### sim/tb_planar_odometry_integrator_top.sv
// Self-checking testbench for the planar odometry integrator: directed table, random and push runs.
`timescale 1ns / 1ps
module tb_planar_odometry_integrator_top;

  localparam int unsigned TBITS      = poi_pkg::ATB;
  localparam int unsigned QTR        = 1 << (TBITS - 2);
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam longint      POS_TOP    = 64'sd140737488355327;
  localparam longint      POS_BOT    = -POS_TOP - 1;

  typedef struct {
    poi_pkg::in_word_t  word;
    bit                 typed;
    poi_pkg::out_word_t pose;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  poi_pkg::in_word_t  in_word_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  poi_pkg::out_word_t out_word_o;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;

  longint             qsin [0:QTR];
  longint             pos_x_now;
  longint             pos_y_now;
  logic [31:0]        heading_now;
  poi_pkg::out_word_t pose_q [$];
  poi_pkg::out_word_t pose_want;
  dir_row_t           dir_rows [$];
  int                 mismatches = 0;
  int                 poses_seen = 0;
  bit                 send_calm = 1'b0;

  planar_odometry_integrator_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_word_o  (out_word_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #12_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t MISMATCH %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(15, 60);
  endfunction

  function automatic longint sine_at(int unsigned idx);
    int unsigned i;
    int unsigned quad;
    int unsigned r;
    longint      v;
    i    = idx % (1 << TBITS);
    quad = i >> (TBITS - 2);
    r    = i & (QTR - 1);
    v    = quad[0] ? qsin[QTR - r] : qsin[r];
    return quad[1] ? -v : v;
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > POS_TOP) return POS_TOP;
    if (v < POS_BOT) return POS_BOT;
    return v;
  endfunction

  function automatic poi_pkg::out_word_t advance_pose(poi_pkg::in_word_t w);
    longint             vf;
    longint             vl;
    longint             yaw;
    longint             dt;
    longint             s;
    longint             c;
    longint             wx;
    longint             wy;
    int unsigned        idx;
    poi_pkg::out_word_t res;
    vf  = longint'($signed(w.vel_forward));
    vl  = longint'($signed(w.vel_left));
    yaw = longint'($signed(w.yaw_rate));
    dt  = longint'(w.elapsed);
    idx = heading_now >> (32 - TBITS);
    s   = sine_at(idx);
    c   = sine_at(idx + QTR);
    wx  = vf * c - vl * s;
    wy  = vf * s + vl * c;
    pos_x_now   = clamp_pos(pos_x_now + ((wx * dt + 256) >>> 9));
    pos_y_now   = clamp_pos(pos_y_now + ((wy * dt + 256) >>> 9));
    heading_now = heading_now + 32'(yaw * dt * 4);
    res.pos_x   = pos_x_now[47:0];
    res.pos_y   = pos_y_now[47:0];
    res.heading = heading_now;
    return res;
  endfunction

  function automatic poi_pkg::in_word_t rand_word();
    poi_pkg::in_word_t w;
    w.vel_forward = 16'($urandom);
    w.vel_left    = 16'($urandom);
    w.yaw_rate    = 24'($urandom);
    w.elapsed     = 16'($urandom);
    case ($urandom_range(0, 9))
      0: w.elapsed = '0;
      1, 2: w.elapsed = 16'($urandom_range(1, 64));
      3: w.yaw_rate = $urandom_range(0, 1) ? 24'h7f_ffff : 24'h80_0000;
      4: begin
        w.vel_forward = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        w.vel_left    = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        w.elapsed     = 16'hffff;
      end
      5: w.yaw_rate = 24'($signed(8'($urandom)));
      default: ;
    endcase
    return w;
  endfunction

  task automatic add_row(int vf, int vl, int yaw, int dt, bit typed = 1'b0,
                         longint x = 0, longint y = 0, longint h = 0);
    dir_row_t r;
    r.word.vel_forward = 16'(vf);
    r.word.vel_left    = 16'(vl);
    r.word.yaw_rate    = 24'(yaw);
    r.word.elapsed     = 16'(dt);
    r.typed            = typed;
    r.pose.pos_x       = 48'(x);
    r.pose.pos_y       = 48'(y);
    r.pose.heading     = 32'(h);
    dir_rows.push_back(r);
  endtask

  task automatic offer(poi_pkg::in_word_t w, bit typed, poi_pkg::out_word_t want);
    poi_pkg::out_word_t pred;
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pred = advance_pose(w);
    pose_q.push_back(typed ? want : pred);
    if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
    if (!send_calm && $urandom_range(0, 1) == 1) begin
      in_valid_i <= 1'b0;
      repeat (idle_len()) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      poses_seen++;
      if (pose_q.size() == 0) begin
        report_mismatch("pose with none pending", out_word_o.heading, '0);
      end else begin
        pose_want = pose_q.pop_front();
        if (out_word_o.pos_x !== pose_want.pos_x)
          report_mismatch("pos_x", out_word_o.pos_x, pose_want.pos_x);
        if (out_word_o.pos_y !== pose_want.pos_y)
          report_mismatch("pos_y", out_word_o.pos_y, pose_want.pos_y);
        if (out_word_o.heading !== pose_want.heading)
          report_mismatch("heading", out_word_o.heading, pose_want.heading);
      end
    end
  end

  initial begin : drain
    int unsigned stall_left;
    bit          calm;
    bit          pressed;
    stall_left = 0;
    calm       = 1'b0;
    pressed    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!pressed && poses_seen >= 40) begin
        pressed    = 1'b1;
        stall_left = 400;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
      end
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [63:0]       ang;
    logic [63:0]       ang2;
    logic [63:0]       term;
    longint            series;
    poi_pkg::in_word_t w;
    int                delta;
    for (int q = 0; q <= int'(QTR); q++) begin
      ang    = (64'(q) * TWO_PI_Q30) >> TBITS;
      ang2   = (ang * ang) >> 30;
      term   = ang;
      series = longint'(ang);
      for (int k = 1; k <= 7; k++) begin
        term   = ((term * ang2) >> 30) / 64'((2 * k) * (2 * k + 1));
        series = (k % 2 == 1) ? series - longint'(term) : series + longint'(term);
      end
      if (series < 0) series = 0;
      series  = (series + 16384) >>> 15;
      qsin[q] = (series > 32767) ? 32767 : series;
    end
    pos_x_now   = 0;
    pos_y_now   = 0;
    heading_now = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(0, 0, 0, 0, 1'b1, 0, 0, 0);
    add_row(1, 0, 0, 0, 1'b1, 0, 0, 0);
    add_row(0, 0, -1, 1, 1'b1, 0, 0, 64'hffff_fffc);
    add_row(0, 0, 1, 1, 1'b1, 0, 0, 0);
    add_row(0, 0, 262144, 1024, 1'b1, 0, 0, 64'h4000_0000);
    add_row(1000, 0, 0, 1024, 1'b1, 0, 65534000, 64'h4000_0000);
    add_row(0, 1000, 0, 1024, 1'b1, -65534000, 65534000, 64'h4000_0000);
    add_row(0, 0, -262144, 1024, 1'b1, -65534000, 65534000, 0);
    add_row(-1, 0, 0, 1);
    add_row(32767, -32768, 8388607, 65535);
    add_row(-32768, 32767, -8388608, 65535);
    add_row(-32768, -32768, 0, 0);
    add_row(12345, -23456, 24'h12_3456, 777);
    add_row(1, 1, 0, 256);
    add_row(500, -700, 524288, 1024);
    add_row(32767, 32767, -1, 65535);
    foreach (dir_rows[i]) offer(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].pose);

    repeat (150) offer(rand_word(), 1'b0, '0);

    // steer the heading into the first table bucket, then push x up and y down hard
    delta       = $signed(32'h0020_0000 - heading_now);
    w           = '0;
    w.yaw_rate  = 24'(delta / 4096);
    w.elapsed   = 16'd1024;
    offer(w, 1'b0, '0);
    repeat (280) begin
      w.vel_forward = 16'($urandom_range(32767, 32000));
      w.vel_left    = 16'(-$urandom_range(32768, 32000));
      w.yaw_rate    = '0;
      w.elapsed     = 16'($urandom_range(65535, 64000));
      offer(w, 1'b0, '0);
    end

    repeat (150) offer(rand_word(), 1'b0, '0);

    in_valid_i <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
